[rtl/blm_pkg.sv]
// Package for the line minimizer: fixed-point types, saturating helpers,
// sequencer states and unit request/response structs.
// No dependencies; compiled first.
package blm_pkg;

    localparam int FRAC_BITS = 40;
    localparam int TOL_W     = 41;
    localparam int MAXEV_W   = 10;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [63:0] t_fix;

    localparam t_fix FIX_MAX = {1'b0, {63{1'b1}}};
    localparam t_fix FIX_MIN = {1'b1, {63{1'b0}}};

    // 0.3819660 truncated, 1e-10 rounded to nearest
    localparam logic [127:0] GOLD_NUM = 128'd3819660 << FRAC_BITS;
    localparam logic [127:0] GOLD_Q   = GOLD_NUM / 128'd10000000;
    localparam t_fix GOLDEN = t_fix'(GOLD_Q[63:0]);
    localparam logic [127:0] TINY_NUM = (128'd1 << FRAC_BITS) + 128'd5000000000;
    localparam logic [127:0] TINY_Q   = TINY_NUM / 128'd10000000000;
    localparam t_fix TINY = t_fix'(TINY_Q[63:0]);

    typedef enum logic {CMD_START = 1'b0, CMD_REPLY = 1'b1} t_cmd;
    typedef enum logic [1:0] {ST_EVAL = 2'd0, ST_CONV = 2'd1, ST_LIMIT = 2'd2} t_status;
    typedef enum logic [1:0] {ACT_KEEP = 2'd0, ACT_SHIFT = 2'd1, ACT_SECOND = 2'd2} t_action;
    typedef enum logic [CFG_IDX_W-1:0] {CFG_TOLERANCE = 1'b0, CFG_MAX_EVAL = 1'b1} t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_UPD, S_LIM, S_TOL, S_TOL2, S_CONV,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_P9, S_P10, S_P11, S_P12, S_P13, S_P14,
        S_G0, S_G1, S_G2, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic command;
        t_fix end_first;
        t_fix middle_point;
        t_fix end_second;
        t_fix objective;
    } t_blm_in;

    typedef struct packed {
        logic [1:0] status;
        t_fix       point;
        t_fix       second_point;
        t_fix       best_value;
        logic [1:0] vector_action;
    } t_blm_out;

    typedef struct packed {
        logic start;
        t_fix a;
        t_fix b;
    } t_unit_req;

    typedef struct packed {
        logic done;
        t_fix res;
    } t_unit_rsp;

    function automatic logic [63:0] mag(t_fix a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic t_fix from_mag(logic neg, logic [63:0] m);
        if (!neg)
            return m[63] ? FIX_MAX : t_fix'(m);
        return m[63] ? FIX_MIN : t_fix'(-m);
    endfunction

    function automatic t_fix sadd(t_fix a, t_fix b);
        t_fix s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? FIX_MIN : FIX_MAX;
        return s;
    endfunction

    function automatic t_fix ssub(t_fix a, t_fix b);
        t_fix s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            return a[63] ? FIX_MIN : FIX_MAX;
        return s;
    endfunction

    function automatic t_fix sabs(t_fix a);
        return from_mag(1'b0, mag(a));
    endfunction

    function automatic t_fix sneg(t_fix a);
        return from_mag(!a[63], mag(a));
    endfunction

    function automatic t_fix signed_like(t_fix m, t_fix s);
        return s[63] ? sneg(sabs(m)) : sabs(m);
    endfunction

    // overflow-free average in offset-binary
    function automatic t_fix midpoint(t_fix a, t_fix b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] m;
        ua = a ^ {1'b1, 63'b0};
        ub = b ^ {1'b1, 63'b0};
        m  = (ua & ub) + ((ua ^ ub) >> 1);
        return t_fix'(m ^ {1'b1, 63'b0});
    endfunction

endpackage

[rtl/blm_in_if.sv]
// Input channel of the line minimizer: valid/ready plus one item.
// Depends on blm_pkg.
interface blm_in_if;
    logic              valid;
    logic              ready;
    blm_pkg::t_blm_in  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/blm_out_if.sv]
// Result channel of the line minimizer: valid/ready plus one result.
// Depends on blm_pkg.
interface blm_out_if;
    logic              valid;
    logic              ready;
    blm_pkg::t_blm_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/blm_mul.sv]
// Sequential fixed-point multiplier: four 32x32 partial products,
// accumulated into 128 bits, then shifted by FRAC_BITS and saturated.
// Depends on blm_pkg.
module blm_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  blm_pkg::t_unit_req i_req,
    output blm_pkg::t_unit_rsp o_rsp
);
    import blm_pkg::*;

    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pidx;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    t_fix         r_res;

    logic [31:0]  ha;
    logic [31:0]  hb;
    logic [127:0] pp_sh;
    logic [63:0]  m;

    // operand halves and aligned partial product
    always_comb begin
        ha = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        hb = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        unique case (r_pidx)
            2'd0:    pp_sh = {64'b0, r_pp};
            2'd3:    pp_sh = {r_pp, 64'b0};
            default: pp_sh = {32'b0, r_pp, 32'b0};
        endcase
        m = (|r_acc[127:64+FRAC_BITS]) ? {64{1'b1}} : r_acc[64+FRAC_BITS-1:FRAC_BITS];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: products at steps 0..3, accumulate at 1..4, finish at 5
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= mag(i_req.a);
            r_mb  <= mag(i_req.b);
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt < 3'd4) begin
                r_pp   <= ha * hb;
                r_pidx <= r_cnt[1:0];
            end
            if (r_cnt != 3'd0 && r_cnt <= 3'd4)
                r_acc <= r_acc + pp_sh;
            if (r_cnt == 3'd5)
                r_res <= from_mag(r_neg, m);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("mul done while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 3'd5) else $error("mul step out of range");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !i_req.start |=> !r_done) else $error("mul done not a pulse");
`endif
endmodule

[rtl/blm_div.sv]
// Restoring divider, one quotient bit per cycle over 128 steps:
// (|p| << FRAC_BITS) / |q|, saturated, signed; zero divisor gives zero.
// Depends on blm_pkg.
module blm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  blm_pkg::t_unit_req i_req,
    output blm_pkg::t_unit_rsp o_rsp
);
    import blm_pkg::*;

    logic [127:0] r_num;
    logic [63:0]  r_den;
    logic [63:0]  r_rem;
    logic [63:0]  r_quo;
    logic         r_ovf;
    logic         r_neg;
    logic         r_zero;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    t_fix         r_res;

    logic [64:0]  rem_sh;
    logic         ge;
    logic [127:0] num0;

    always_comb begin
        num0   = {64'b0, mag(i_req.a)} << FRAC_BITS;
        rem_sh = {r_rem, r_num[127]};
        ge     = rem_sh[64] || (rem_sh[63:0] >= r_den);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 8'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd128) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one shift-subtract step a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= num0;
            r_den  <= mag(i_req.b);
            r_zero <= (i_req.b == '0);
            r_neg  <= i_req.a[63] ^ i_req.b[63];
            r_rem  <= '0;
            r_quo  <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt[7] == 1'b0) begin
                r_num <= {r_num[126:0], 1'b0};
                r_ovf <= r_ovf | r_quo[63];
                r_quo <= {r_quo[62:0], ge};
                r_rem <= ge ? (rem_sh[63:0] - r_den) : rem_sh[63:0];
            end else begin
                r_res <= r_zero ? '0 : from_mag(r_neg, r_ovf ? {64{1'b1}} : r_quo);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("div done while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 8'd128) else $error("div step out of range");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !i_req.start |=> !r_done) else $error("div done not a pulse");
`endif
endmodule

[rtl/brent_line_minimizer_core.sv]
// Brent line minimizer controller: sequencer, search state and result register.
// Depends on blm_pkg, blm_in_if, blm_out_if, blm_mul, blm_div.
//
//  channel   dir  beat
//  i_item    in   command, bracket a/b/c, objective
//  o_result  out  status, point, second_point, best_value, vector_action
//  i_cfg_*   in   index 0 tolerance, index 1 max_evaluations
//
// One beat at a time: after the accepting edge the sequencer goes through
// S_START or S_UPD to S_LIM, which gives a limit answer; convergence is decided
// after the tolerance multiply, a golden step adds one multiplier pass and a
// parabolic step uses up to eight multiplier passes and one divider pass. Reset is synchronous and
// needs no sweep. A result holds until taken; no beat is accepted meanwhile.
module brent_line_minimizer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    blm_in_if.sink                            i_item,
    blm_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [blm_pkg::TOL_W-1:0]         i_cfg_data
);
    import blm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_searching;
    logic [TOL_W-1:0]   r_tol;
    logic [MAXEV_W-1:0] r_maxev;
    logic [MAXEV_W-1:0] r_cnt;

    t_fix r_a, r_b, r_x, r_w, r_v, r_fx, r_fw, r_fv;
    t_fix r_step_now, r_step_before, r_pu;
    t_fix r_fu, r_ax, r_bx, r_cx;
    logic [1:0] r_act;
    t_fix r_xm, r_tol1, r_tol2, r_half;
    t_fix r_dxw, r_dxv, r_t2, r_r, r_q, r_p, r_eold, r_hq, r_lo, r_hi;
    t_fix r_d, r_e, r_u;
    t_blm_out r_out;

    t_unit_req mul_req;
    t_unit_req div_req;
    t_unit_rsp mul_rsp;
    t_unit_rsp div_rsp;

    logic in_acc;
    t_fix tol_fix;
    t_fix sel_d;
    t_fix pu;
    logic conv;
    logic gold_p;
    logic near_end;

    blm_mul u_mul (.i_clk, .i_rst_n, .i_req(mul_req), .o_rsp(mul_rsp));
    blm_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    assign i_item.ready   = (r_state == S_IDLE);
    assign in_acc         = i_item.valid && i_item.ready;
    assign o_result.valid = (r_state == S_OUT);
    assign o_result.payload = r_out;
    assign tol_fix        = t_fix'({{(64-TOL_W){1'b0}}, r_tol});

    // tests that feed the sequencer
    always_comb begin
        conv     = sabs(ssub(r_x, r_xm)) <= ssub(r_tol2, r_half);
        gold_p   = (sabs(r_p) >= r_hq) || (r_p <= r_lo) || (r_p >= r_hi);
        near_end = (ssub(r_u, r_a) < r_tol2) || (ssub(r_b, r_u) < r_tol2);
        sel_d    = (sabs(r_d) >= r_tol1) ? r_d : signed_like(r_tol1, r_d);
        pu       = sadd(r_x, sel_d);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_W'(109951);
            r_maxev <= MAXEV_W'(100);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TOLERANCE: r_tol   <= i_cfg_data;
                CFG_MAX_EVAL:  r_maxev <= i_cfg_data[MAXEV_W-1:0];
                default:       r_tol   <= r_tol;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // next state and unit requests
    always_comb begin
        n_state = r_state;
        mul_req = '0;
        div_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_item.payload.command == CMD_START)
                        n_state = S_START;
                    else if (r_searching)
                        n_state = S_UPD;
                end
            end
            S_START, S_UPD: n_state = S_LIM;
            S_LIM: begin
                if (r_cnt >= r_maxev) begin
                    n_state = S_OUT;
                end else begin
                    mul_req = '{1'b1, tol_fix, sabs(r_x)};
                    n_state = S_TOL;
                end
            end
            S_TOL:  if (mul_rsp.done) n_state = S_TOL2;
            S_TOL2: n_state = S_CONV;
            S_CONV: begin
                if (conv)
                    n_state = S_OUT;
                else if (sabs(r_step_before) > r_tol1)
                    n_state = S_P0;
                else
                    n_state = S_G0;
            end
            S_P0: begin
                mul_req = '{1'b1, ssub(r_x, r_w), ssub(r_fx, r_fv)};
                n_state = S_P1;
            end
            S_P1: begin
                if (mul_rsp.done) begin
                    mul_req = '{1'b1, r_dxv, r_t2};
                    n_state = S_P2;
                end
            end
            S_P2: begin
                if (mul_rsp.done) begin
                    mul_req = '{1'b1, r_dxv, mul_rsp.res};
                    n_state = S_P3;
                end
            end
            S_P3: begin
                if (mul_rsp.done) begin
                    mul_req = '{1'b1, r_dxw, r_r};
                    n_state = S_P4;
                end
            end
            S_P4:  if (mul_rsp.done) n_state = S_P5;
            S_P5:  n_state = S_P6;
            S_P6:  n_state = S_P7;
            S_P7: begin
                mul_req = '{1'b1, r_q, r_eold};
                n_state = S_P8;
            end
            S_P8: begin
                if (mul_rsp.done) begin
                    mul_req = '{1'b1, r_q, ssub(r_a, r_x)};
                    n_state = S_P9;
                end
            end
            S_P9: begin
                if (mul_rsp.done) begin
                    mul_req = '{1'b1, r_q, ssub(r_b, r_x)};
                    n_state = S_P10;
                end
            end
            S_P10: if (mul_rsp.done) n_state = S_P11;
            S_P11: begin
                if (gold_p) begin
                    n_state = S_G0;
                end else begin
                    div_req = '{1'b1, r_p, r_q};
                    n_state = S_P12;
                end
            end
            S_P12: if (div_rsp.done) n_state = S_P13;
            S_P13: n_state = S_P14;
            S_P14: n_state = S_FIN;
            S_G0:  n_state = S_G1;
            S_G1: begin
                mul_req = '{1'b1, GOLDEN, r_e};
                n_state = S_G2;
            end
            S_G2:  if (mul_rsp.done) n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: if (o_result.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // search flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_searching <= 1'b0;
        end else if (r_state == S_START) begin
            r_searching <= 1'b1;
        end else if ((r_state == S_LIM && r_cnt >= r_maxev) || (r_state == S_CONV && conv)) begin
            r_searching <= 1'b0;
        end
    end

    // search state, scratch registers and result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_ax  <= i_item.payload.end_first;
                    r_bx  <= i_item.payload.middle_point;
                    r_cx  <= i_item.payload.end_second;
                    r_fu  <= i_item.payload.objective;
                end
            end
            S_START: begin
                r_a  <= (r_ax < r_cx) ? r_ax : r_cx;
                r_b  <= (r_ax > r_cx) ? r_ax : r_cx;
                r_x  <= r_bx;
                r_w  <= r_bx;
                r_v  <= r_bx;
                r_fx <= r_fu;
                r_fw <= r_fu;
                r_fv <= r_fu;
                r_step_now    <= '0;
                r_step_before <= '0;
                r_pu  <= '0;
                r_cnt <= '0;
                r_act <= ACT_KEEP;
            end
            S_UPD: begin
                r_cnt <= r_cnt + MAXEV_W'(1);
                r_act <= ACT_KEEP;
                if (r_fu <= r_fx) begin
                    if (r_pu >= r_x)
                        r_a <= r_x;
                    else
                        r_b <= r_x;
                    r_v  <= r_w;
                    r_w  <= r_x;
                    r_x  <= r_pu;
                    r_fv <= r_fw;
                    r_fw <= r_fx;
                    r_fx <= r_fu;
                    r_act <= ACT_SHIFT;
                end else begin
                    if (r_pu < r_x)
                        r_a <= r_pu;
                    else
                        r_b <= r_pu;
                    priority if (r_fu <= r_fw || r_w == r_x) begin
                        r_v  <= r_w;
                        r_w  <= r_pu;
                        r_fv <= r_fw;
                        r_fw <= r_fu;
                        r_act <= ACT_SECOND;
                    end else if (r_fu <= r_fv || r_v == r_x || r_v == r_w) begin
                        r_v  <= r_pu;
                        r_fv <= r_fu;
                    end else begin
                        r_v <= r_v;
                    end
                end
            end
            S_LIM: begin
                r_xm   <= midpoint(r_a, r_b);
                r_half <= (r_b >= r_a) ? t_fix'(64'(r_b - r_a) >> 1) : '0;
                r_out  <= '{ST_LIMIT, r_x, r_w, r_fx, r_act};
            end
            S_TOL:  if (mul_rsp.done) r_tol1 <= sadd(mul_rsp.res, TINY);
            S_TOL2: r_tol2 <= sadd(r_tol1, r_tol1);
            S_CONV: begin
                r_d   <= r_step_now;
                r_e   <= r_step_before;
                r_out <= '{ST_CONV, r_x, r_w, r_fx, r_act};
            end
            S_P0: begin
                r_dxw <= ssub(r_x, r_w);
                r_dxv <= ssub(r_x, r_v);
                r_t2  <= ssub(r_fx, r_fw);
            end
            S_P1:  if (mul_rsp.done) r_r <= mul_rsp.res;
            S_P2:  if (mul_rsp.done) r_q <= mul_rsp.res;
            S_P3:  if (mul_rsp.done) r_p <= mul_rsp.res;
            S_P4: begin
                if (mul_rsp.done) begin
                    r_p <= ssub(r_p, mul_rsp.res);
                    r_q <= ssub(r_q, r_r);
                end
            end
            S_P5:  r_q <= sadd(r_q, r_q);
            S_P6: begin
                // q > 0 flips the numerator sign
                if (!r_q[63] && r_q != '0)
                    r_p <= sneg(r_p);
                r_q    <= sabs(r_q);
                r_eold <= r_e;
                r_e    <= r_d;
            end
            S_P8:  if (mul_rsp.done) r_hq <= t_fix'(mag(mul_rsp.res) >> 1);
            S_P9:  if (mul_rsp.done) r_lo <= mul_rsp.res;
            S_P10: if (mul_rsp.done) r_hi <= mul_rsp.res;
            S_P12: if (div_rsp.done) r_d <= div_rsp.res;
            S_P13: r_u <= sadd(r_x, r_d);
            S_P14: if (near_end) r_d <= signed_like(r_tol1, ssub(r_xm, r_x));
            S_G0:  r_e <= (r_x >= r_xm) ? ssub(r_a, r_x) : ssub(r_b, r_x);
            S_G2:  if (mul_rsp.done) r_d <= mul_rsp.res;
            S_FIN: begin
                r_step_now    <= r_d;
                r_step_before <= r_e;
                r_pu          <= pu;
                r_out         <= '{ST_EVAL, pu, '0, r_fx, r_act};
            end
            default: r_out <= r_out;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_item.ready && o_result.valid)) else $error("accepting while result pending");
    a_eval_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.status == ST_EVAL
        |-> o_result.payload.second_point == '0) else $error("second point set on eval");
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.status != ST_EVAL |-> !r_searching)
        else $error("search still running after final result");
    a_eval_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.status == ST_EVAL |-> r_searching)
        else $error("eval result while idle");
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_state == S_IDLE) else $error("not idle after reset");
`endif
endmodule

[tb/sv/blm_checker.sv]
// Line minimizer checker: watches the item, result and register ports,
// predicts every result from its own copy of the search state and compares.
// Depends on blm_pkg, blm_in_if and blm_out_if.
module blm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    blm_in_if                                 i_item,
    blm_out_if                                i_result,
    input  logic                              i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [blm_pkg::TOL_W-1:0]         i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import blm_pkg::*;

    localparam logic [127:0] GOLD_W = (128'd3819660 << FRAC_BITS) / 128'd10000000;
    localparam logic [127:0] TINY_W =
        ((128'd1 << FRAC_BITS) + 128'd5000000000) / 128'd10000000000;
    localparam t_fix GOLD_STEP = t_fix'(GOLD_W[63:0]);
    localparam t_fix TINY_TOL  = t_fix'(TINY_W[63:0]);
    localparam t_fix POS_LIM   = {1'b0, {63{1'b1}}};
    localparam t_fix NEG_LIM   = {1'b1, {63{1'b0}}};

    // register copies
    logic [TOL_W-1:0]   tol_rel;
    logic [MAXEV_W-1:0] eval_cap;

    // search state
    t_fix lo_x, hi_x, x_best, x_sec, x_old;
    t_fix f_best, f_sec, f_old;
    t_fix step_d, step_e, u_prop;
    logic [MAXEV_W-1:0] n_evals;
    logic               active;

    t_blm_out expected_results[$];

    // fixed-point arithmetic, saturating
    function automatic t_fix clip_mag(logic neg, logic [63:0] m);
        if (!neg)
            return m[63] ? POS_LIM : t_fix'(m);
        return m[63] ? NEG_LIM : -t_fix'(m);
    endfunction

    function automatic logic [63:0] abs_u(t_fix a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic t_fix add_s(t_fix a, t_fix b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(POS_LIM)) return POS_LIM;
        if (s < 65'(NEG_LIM)) return NEG_LIM;
        return s[63:0];
    endfunction

    function automatic t_fix sub_s(t_fix a, t_fix b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'(POS_LIM)) return POS_LIM;
        if (s < 65'(NEG_LIM)) return NEG_LIM;
        return s[63:0];
    endfunction

    function automatic t_fix abs_s(t_fix a);
        return clip_mag(1'b0, abs_u(a));
    endfunction

    function automatic t_fix neg_s(t_fix a);
        return clip_mag(!a[63], abs_u(a));
    endfunction

    function automatic t_fix mul_s(t_fix a, t_fix b);
        logic [127:0] pr;
        logic [63:0]  m;
        pr = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
        m  = (pr[127:64+FRAC_BITS] != 0) ? {64{1'b1}} : pr[63+FRAC_BITS:FRAC_BITS];
        return clip_mag(a[63] != b[63], m);
    endfunction

    function automatic t_fix div_s(t_fix p, t_fix q);
        logic [127:0] quo;
        logic [63:0]  m;
        if (q == 0) return 0;
        quo = ({64'd0, abs_u(p)} << FRAC_BITS) / {64'd0, abs_u(q)};
        m   = (quo[127:64] != 0) ? {64{1'b1}} : quo[63:0];
        return clip_mag(p[63] != q[63], m);
    endfunction

    function automatic t_fix mid_s(t_fix a, t_fix b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64:1];
    endfunction

    function automatic t_fix with_sign(t_fix m, t_fix s);
        return s[63] ? neg_s(abs_s(m)) : abs_s(m);
    endfunction

    // limit check, convergence test and next proposal
    task automatic next_move(input logic [1:0] act, output t_blm_out r);
        t_fix xm, tol1, tol2, half, d, e, dxw, dxv, rr, qq, pp, eold, hq, u;
        logic gold;
        gold = 1'b1;
        r = '0;
        r.vector_action = act;
        r.best_value    = f_best;
        if (n_evals >= eval_cap) begin
            active = 1'b0;
            r.status = ST_LIMIT; r.point = x_best; r.second_point = x_sec;
            return;
        end
        xm   = mid_s(lo_x, hi_x);
        tol1 = add_s(mul_s(t_fix'({23'd0, tol_rel}), abs_s(x_best)), TINY_TOL);
        tol2 = add_s(tol1, tol1);
        half = (hi_x >= lo_x) ? t_fix'((64'(hi_x) - 64'(lo_x)) >> 1) : 0;
        if (abs_s(sub_s(x_best, xm)) <= sub_s(tol2, half)) begin
            active = 1'b0;
            r.status = ST_CONV; r.point = x_best; r.second_point = x_sec;
            return;
        end
        d = step_d;
        e = step_e;
        if (abs_s(e) > tol1) begin
            dxw  = sub_s(x_best, x_sec);
            dxv  = sub_s(x_best, x_old);
            rr   = mul_s(dxw, sub_s(f_best, f_old));
            qq   = mul_s(dxv, sub_s(f_best, f_sec));
            pp   = sub_s(mul_s(dxv, qq), mul_s(dxw, rr));
            eold = e;
            qq   = sub_s(qq, rr);
            qq   = add_s(qq, qq);
            if (qq > 0) pp = neg_s(pp);
            qq   = abs_s(qq);
            e    = d;
            hq   = t_fix'(abs_u(mul_s(qq, eold)) >> 1);
            if (!(abs_s(pp) >= hq || pp <= mul_s(qq, sub_s(lo_x, x_best)) ||
                  pp >= mul_s(qq, sub_s(hi_x, x_best)))) begin
                gold = 1'b0;
                d = div_s(pp, qq);
                u = add_s(x_best, d);
                if (sub_s(u, lo_x) < tol2 || sub_s(hi_x, u) < tol2)
                    d = with_sign(tol1, sub_s(xm, x_best));
            end
        end
        if (gold) begin
            e = (x_best >= xm) ? sub_s(lo_x, x_best) : sub_s(hi_x, x_best);
            d = mul_s(GOLD_STEP, e);
        end
        step_d = d;
        step_e = e;
        u_prop = (abs_s(d) >= tol1) ? add_s(x_best, d) : add_s(x_best, with_sign(tol1, d));
        r.status = ST_EVAL;
        r.point  = u_prop;
    endtask

    // one accepted item: update the search, queue the result if any
    task automatic take_item(input t_blm_in it);
        t_blm_out r;
        t_fix fu, u, x;
        logic [1:0] act;
        fu  = it.objective;
        act = ACT_KEEP;
        if (it.command == CMD_START) begin
            lo_x   = (it.end_first < it.end_second) ? it.end_first : it.end_second;
            hi_x   = (it.end_first > it.end_second) ? it.end_first : it.end_second;
            x_best = it.middle_point; x_sec = it.middle_point; x_old = it.middle_point;
            f_best = fu; f_sec = fu; f_old = fu;
            step_d = 0; step_e = 0; u_prop = 0;
            n_evals = 0;
            active  = 1'b1;
        end else begin
            if (!active) return;      // reply while idle is dropped
            u = u_prop;
            x = x_best;
            if (fu <= f_best) begin
                if (u >= x) lo_x = x; else hi_x = x;
                x_old = x_sec;  x_sec = x;  x_best = u;
                f_old = f_sec;  f_sec = f_best; f_best = fu;
                act = ACT_SHIFT;
            end else begin
                if (u < x) lo_x = u; else hi_x = u;
                if (fu <= f_sec || x_sec == x) begin
                    x_old = x_sec; x_sec = u;
                    f_old = f_sec; f_sec = fu;
                    act = ACT_SECOND;
                end else if (fu <= f_old || x_old == x || x_old == x_sec) begin
                    x_old = u;
                    f_old = fu;
                end
            end
            n_evals = n_evals + 1'b1;
        end
        next_move(act, r);
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_blm_out e;
        t_blm_out a;
        if (!i_rst_n) begin
            tol_rel = 41'd109951; eval_cap = 10'd100;
            lo_x = 0; hi_x = 0; x_best = 0; x_sec = 0; x_old = 0;
            f_best = 0; f_sec = 0; f_old = 0;
            step_d = 0; step_e = 0; u_prop = 0;
            n_evals = 0; active = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TOLERANCE: tol_rel  = i_cfg_data;
                    CFG_MAX_EVAL:  eval_cap = i_cfg_data[MAXEV_W-1:0];
                    default: ;
                endcase
            end
            // result beat first: it belongs to an earlier item
            if (i_result.valid && i_result.ready) begin
                a = i_result.payload;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, a);
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", 64'(e.status), 64'(a.status));
                    check_field("point", e.point, a.point);
                    check_field("second_point", e.second_point, a.second_point);
                    check_field("best_value", e.best_value, a.best_value);
                    check_field("vector_action", 64'(e.vector_action), 64'(a.vector_action));
                end
            end
            if (i_item.valid && i_item.ready)
                take_item(i_item.payload);
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/sv/tb_top.sv]
// Line minimizer testbench top: clock, reset, item and register stimulus,
// result handshake and the verdict. Depends on blm_pkg, the channel
// interfaces, brent_line_minimizer_core and blm_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import blm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TARGET_BEATS = 650;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TOL_W-1:0]     i_cfg_data;

    blm_in_if  item_ch ();
    blm_out_if result_ch ();

    int errors, pending;
    int tx_idle, rx_idle;
    int beats_sent, results_seen, cycles;
    bit hold_req;
    t_blm_out last_result;

    brent_line_minimizer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_ch.sink), .o_result(result_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    blm_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(item_ch), .i_result(result_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result beats seen by the stimulus side
    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready) begin
            last_result  <= result_ch.payload;
            results_seen <= results_seen + 1;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    function automatic t_fix rand_fix();
        return t_fix'({$urandom, $urandom});
    endfunction

    // bowl-shaped objective around a target point
    function automatic t_fix bowl(t_fix u, t_fix tgt, int sh);
        logic signed [64:0]  dd;
        logic signed [127:0] s, sq;
        dd = 65'(u) - 65'(tgt);
        s  = 128'(dd) >>> sh;
        sq = s * s;
        if (sq > 128'sh7fff_ffff_ffff_ffff) return {1'b0, {63{1'b1}}};
        return sq[63:0];
    endfunction

    task automatic send_beat(input t_blm_in it);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        beats_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
    endtask

    // send one beat and wait for its result; earlier results are all
    // taken by the time the block accepts the beat
    task automatic send_wait(input t_blm_in it);
        int seen;
        send_beat(it);
        seen = results_seen;
        drop_valid();
        wait (results_seen > seen);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [TOL_W-1:0] val);
        wait (pending == 0);
        repeat (300) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_blm_in reply_of(t_fix f);
        t_blm_in it;
        it = '0;
        it.command    = CMD_REPLY;
        it.end_first  = rand_fix();
        it.middle_point = rand_fix();
        it.end_second = rand_fix();
        it.objective  = f;
        return it;
    endfunction

    // well-formed search around a random minimum, cut short at max_replies
    task automatic run_search(input int max_replies, input bit noisy);
        t_blm_in it;
        t_fix tgt, f;
        int sh, k, wid;
        wid = $urandom_range(60, 20);
        sh  = $urandom_range(30, 10);
        tgt = t_fix'($signed({{2{1'b0}}, $urandom, $urandom}) >>> 2) -
              (t_fix'(1) <<< 60);
        it = '0;
        it.command      = CMD_START;
        it.end_first    = tgt - t_fix'({$urandom, $urandom} >> (64 - wid));
        it.end_second   = tgt + t_fix'({$urandom, $urandom} >> (64 - wid));
        if ($urandom_range(1)) begin
            f = it.end_first; it.end_first = it.end_second; it.end_second = f;
        end
        it.middle_point = tgt + t_fix'({$urandom, $urandom} >> (66 - wid));
        it.objective    = bowl(it.middle_point, tgt, sh);
        send_wait(it);
        for (k = 0; k < max_replies && last_result.status == ST_EVAL; k++) begin
            f = bowl(last_result.point, tgt, sh);
            if (noisy && $urandom_range(9) == 0) f = rand_fix();
            send_wait(reply_of(f));
        end
    endtask

    // blind beats while the receiver holds off, so the block backs up
    task automatic flood();
        t_blm_in it;
        int k;
        hold_req = 1'b1;
        for (k = 0; k < 6; k++) begin
            it = t_blm_in'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom});
            send_beat(it);
        end
        drop_valid();
    endtask

    initial begin
        t_blm_in it;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_TOLERANCE; i_cfg_data = '0;
        tx_idle = 0; rx_idle = 0;
        beats_sent = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reply while idle gets no result
        send_beat(reply_of(rand_fix()));
        drop_valid();
        // full-range bracket with extreme objectives
        it = '0;
        it.command = CMD_START;
        it.end_first = {1'b1, {63{1'b0}}}; it.middle_point = 0;
        it.end_second = {1'b0, {63{1'b1}}}; it.objective = {1'b0, {63{1'b1}}};
        send_wait(it);
        send_wait(reply_of({1'b1, {63{1'b0}}}));
        send_wait(reply_of({1'b0, {63{1'b1}}}));
        send_wait(reply_of(0));
        send_wait(reply_of(-1));
        // reversed ends, middle outside the bracket; then restart mid-search
        it.end_first = t_fix'(64'sd5 <<< 40); it.end_second = -t_fix'(64'sd3 <<< 40);
        it.middle_point = t_fix'(64'sd9 <<< 40); it.objective = -t_fix'(64'sd1);
        send_wait(it);
        send_wait(reply_of(t_fix'(64'sd7)));
        run_search(4, 1'b0);
        // evaluation limit of one
        cfg_write(CFG_MAX_EVAL, 1);
        run_search(3, 1'b0);
        // tolerance extremes
        cfg_write(CFG_TOLERANCE, 41'h100_0000_0000);
        run_search(3, 1'b0);
        cfg_write(CFG_TOLERANCE, 0);
        cfg_write(CFG_MAX_EVAL, 10'h3ff);
        run_search(6, 1'b0);
        send_beat(reply_of(rand_fix()));
        drop_valid();

        // random: three idle profiles, register changes between searches
        while (beats_sent < TARGET_BEATS) begin
            if (beats_sent < TARGET_BEATS / 3) begin
                tx_idle = 30; rx_idle = 65;
            end else if (beats_sent < 2 * TARGET_BEATS / 3) begin
                tx_idle = 65; rx_idle = 30;
            end else begin
                tx_idle = 0; rx_idle = 0;
            end
            case ($urandom_range(19))
                0: cfg_write(CFG_TOLERANCE, $urandom_range(3) == 0 ?
                             41'h100_0000_0000 : 41'({$urandom, $urandom} >> $urandom_range(63, 23)));
                1: cfg_write(CFG_MAX_EVAL, $urandom_range(1) ? 10'($urandom_range(40, 1)) : 10'h3ff);
                2: flood();
                3: begin
                    send_beat(reply_of(rand_fix()));
                    drop_valid();
                end
                default: run_search($urandom_range(40, 1), $urandom_range(3) == 0);
            endcase
        end
        cfg_write(CFG_TOLERANCE, 41'd109951);
        cfg_write(CFG_MAX_EVAL, 10'd100);
        tx_idle = 0; rx_idle = 0;
        run_search(40, 1'b0);

        wait (pending == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/blm_pkg.sv
rtl/blm_in_if.sv
rtl/blm_out_if.sv
rtl/blm_mul.sv
rtl/blm_div.sv
rtl/brent_line_minimizer_core.sv
tb/sv/blm_checker.sv
tb/sv/tb_top.sv
